>>> hw/rtl/lm3d_pkg.sv
// Shared constants, types and helpers for the 3-D local extremum detector.
// No dependencies; used by local_maxima_3d_mask and its port checker.
package lm3d_pkg;

  localparam int unsigned MAX_X = 256;
  localparam int unsigned MAX_Y = 256;
  localparam int unsigned MAX_Z = 256;

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);

  localparam int unsigned PLANE_DEPTH = MAX_X * MAX_Y;
  localparam int unsigned PA_W        = $clog2(PLANE_DEPTH);

  localparam int unsigned VOX_W     = 16;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CIDX_W    = 24;
  localparam int unsigned CNT_W     = 25;
  localparam int unsigned NEIGHBORS = 26;

  typedef logic signed [VOX_W-1:0] vox_t;
  // index 0 = current plane, 1 = one plane back, 2 = two planes back
  typedef vox_t [2:0] trip_t;
  // plane memory word: [1] = one plane back, [0] = two planes back
  typedef vox_t [1:0] ppair_t;
  // row memory word: [0] = one row back, [1] = two rows back
  typedef trip_t [1:0] rpair_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X      = 3'd0,
    CFG_SIZE_Y      = 3'd1,
    CFG_SIZE_Z      = 3'd2,
    CFG_CUTOFF      = 3'd3,
    CFG_FIND_MINIMA = 3'd4,
    CFG_STRICT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              first;   // voxel opens a volume
    logic              cvalid;  // window is full
    logic              inner;   // center is off every face
    logic [CIDX_W-1:0] cidx;    // raster index of the center
  } ctl_t;

  // Last position along one axis for a written size; the size is clamped to [3, hi].
  function automatic logic [31:0] size_last(input logic [SIZE_W-1:0] v,
                                            input logic [31:0] hi);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd3) begin
      return 32'd2;
    end
    if (w > hi) begin
      return hi - 32'd1;
    end
    return w - 32'd1;
  endfunction

endpackage

>>> hw/rtl/local_maxima_3d_mask.sv
// Top level of the streaming 3-D local extremum detector (26-neighbor window).
// Depends on lm3d_pkg and lm3d_ram.

// Voxels enter in raster order (x fastest), one per clock when neither side
// stalls, and each accepted voxel yields one result: the decision for the
// voxel one plane, one row and one voxel back, its raster index and the
// running extremum count of the volume. Each voxel is registered in stage 1,
// stage 2 and the output register, in that order. The rate of one voxel per
// clock is set by the plane memory, which is read and written once per voxel
// (read at acceptance, written back one stage later); a row memory of MAX_X
// words does the same per row, and a 3x3x3 register window closes the x axis.
// Memories need no clearing pass after reset: a decision only uses entries
// written earlier in the same volume. Writing any size register restarts the
// volume; configure only while no transaction is in flight.
module local_maxima_3d_mask (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lm3d_pkg::VOX_W-1:0]     in_voxel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_center_valid,
  output logic [lm3d_pkg::CIDX_W-1:0]           out_center_index,
  output logic                                  out_is_extremum,
  output logic [lm3d_pkg::CNT_W-1:0]            out_extremum_count,
  input  logic                                  cfg_we,
  input  logic [lm3d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lm3d_pkg::CFG_W-1:0]            cfg_data
);

  // configuration
  logic [lm3d_pkg::XW-1:0] lastx_r;
  logic [lm3d_pkg::YW-1:0] lasty_r;
  logic [lm3d_pkg::ZW-1:0] lastz_r;
  lm3d_pkg::vox_t          cutoff_r;
  logic                    fmin_r;
  logic                    strict_r;

  logic        wr_sx, wr_sy, wr_sz, wr_cut, wr_fmin, wr_strict, restart;
  logic [31:0] lx_cfg, ly_cfg, lz_cfg;

  // raster position
  logic [lm3d_pkg::XW-1:0]     px_r, px_nxt;
  logic [lm3d_pkg::YW-1:0]     py_r, py_nxt;
  logic [lm3d_pkg::ZW-1:0]     pz_r, pz_nxt;
  logic [lm3d_pkg::PA_W-1:0]   pa_r, pa_nxt;
  logic [lm3d_pkg::CIDX_W-1:0] cidx_r, cidx_nxt;
  logic                        x_end, y_end, z_end;
  lm3d_pkg::ctl_t              acc_ctl;

  // handshake
  logic out_take, s2_free, s2_adv, s1_free, s1_adv, acc;

  // stage 1: memory read data lines up with the voxel
  logic                      s1_v_r;
  lm3d_pkg::vox_t            s1_vox_r;
  logic [lm3d_pkg::PA_W-1:0] s1_pa_r;
  logic [lm3d_pkg::XW-1:0]   s1_x_r;
  lm3d_pkg::ctl_t            s1_ctl_r;
  lm3d_pkg::ppair_t          plane_rd, plane_wd;
  lm3d_pkg::rpair_t          row_rd, row_wd;
  lm3d_pkg::trip_t           cur_trip;
  lm3d_pkg::vox_t            col [3][3];

  // stage 2: full window, decision
  logic           s2_v_r;
  lm3d_pkg::ctl_t s2_ctl_r;
  lm3d_pkg::vox_t win_r [3][3][3];
  lm3d_pkg::vox_t center;
  logic [lm3d_pkg::NEIGHBORS-1:0] nb_ok;
  logic           thr_ok, s2_ext;
  logic [lm3d_pkg::CNT_W-1:0] cnt_base, cnt_nxt;

  // output register
  logic                        out_v_r;
  logic                        out_cv_r;
  logic [lm3d_pkg::CIDX_W-1:0] out_idx_r;
  logic                        out_ext_r;
  logic [lm3d_pkg::CNT_W-1:0]  cnt_r;

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  always_comb begin
    wr_sx     = 1'b0;
    wr_sy     = 1'b0;
    wr_sz     = 1'b0;
    wr_cut    = 1'b0;
    wr_fmin   = 1'b0;
    wr_strict = 1'b0;
    if (cfg_we) begin
      unique case (lm3d_pkg::cfg_reg_t'(cfg_index))
        lm3d_pkg::CFG_SIZE_X:      wr_sx     = 1'b1;
        lm3d_pkg::CFG_SIZE_Y:      wr_sy     = 1'b1;
        lm3d_pkg::CFG_SIZE_Z:      wr_sz     = 1'b1;
        lm3d_pkg::CFG_CUTOFF:      wr_cut    = 1'b1;
        lm3d_pkg::CFG_FIND_MINIMA: wr_fmin   = 1'b1;
        lm3d_pkg::CFG_STRICT:      wr_strict = 1'b1;
        default: ;
      endcase
    end
    restart = wr_sx || wr_sy || wr_sz;
    lx_cfg  = lm3d_pkg::size_last(cfg_data[lm3d_pkg::SIZE_W-1:0], 32'(lm3d_pkg::MAX_X));
    ly_cfg  = lm3d_pkg::size_last(cfg_data[lm3d_pkg::SIZE_W-1:0], 32'(lm3d_pkg::MAX_Y));
    lz_cfg  = lm3d_pkg::size_last(cfg_data[lm3d_pkg::SIZE_W-1:0], 32'(lm3d_pkg::MAX_Z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lastx_r  <= lm3d_pkg::XW'(lm3d_pkg::MAX_X - 1);
      lasty_r  <= lm3d_pkg::YW'(lm3d_pkg::MAX_Y - 1);
      lastz_r  <= lm3d_pkg::ZW'(lm3d_pkg::MAX_Z - 1);
      cutoff_r <= '0;
      fmin_r   <= 1'b0;
      strict_r <= 1'b0;
    end else begin
      if (wr_sx) begin
        lastx_r <= lx_cfg[lm3d_pkg::XW-1:0];
      end
      if (wr_sy) begin
        lasty_r <= ly_cfg[lm3d_pkg::YW-1:0];
      end
      if (wr_sz) begin
        lastz_r <= lz_cfg[lm3d_pkg::ZW-1:0];
      end
      if (wr_cut) begin
        cutoff_r <= cfg_data[lm3d_pkg::VOX_W-1:0];
      end
      if (wr_fmin) begin
        fmin_r <= cfg_data[0];
      end
      if (wr_strict) begin
        strict_r <= cfg_data[0];
      end
    end
  end

  //--------------------------------------------------------------------------
  // handshake: each stage fills as soon as the one after it frees up
  //--------------------------------------------------------------------------
  assign out_take = !out_v_r || !out_stall;
  assign s2_free  = !s2_v_r || out_take;
  assign s2_adv   = s2_v_r && out_take;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign acc      = in_valid && s1_free;
  assign in_stall = !s1_free;

  //--------------------------------------------------------------------------
  // raster position and per-voxel control
  //--------------------------------------------------------------------------
  always_comb begin
    x_end = (px_r == lastx_r);
    y_end = (py_r == lasty_r);
    z_end = (pz_r == lastz_r);

    acc_ctl.first  = (px_r == '0) && (py_r == '0) && (pz_r == '0);
    // window full once position reaches (1,1,1) in plane/row/voxel order
    acc_ctl.cvalid = (pz_r[lm3d_pkg::ZW-1:1] != '0) ||
                     ((pz_r[lm3d_pkg::ZW-1:1] == '0) && pz_r[0] &&
                      ((py_r[lm3d_pkg::YW-1:1] != '0) ||
                       ((py_r[lm3d_pkg::YW-1:1] == '0) && py_r[0] && (px_r != '0))));
    // center is (x-1, y-1, z-1); it is off every face when x, y, z >= 2
    acc_ctl.inner  = (px_r[lm3d_pkg::XW-1:1] != '0) &&
                     (py_r[lm3d_pkg::YW-1:1] != '0) &&
                     (pz_r[lm3d_pkg::ZW-1:1] != '0);
    acc_ctl.cidx   = cidx_r;

    px_nxt   = px_r;
    py_nxt   = py_r;
    pz_nxt   = pz_r;
    pa_nxt   = pa_r;
    cidx_nxt = cidx_r;
    if (restart) begin
      px_nxt   = '0;
      py_nxt   = '0;
      pz_nxt   = '0;
      pa_nxt   = '0;
      cidx_nxt = '0;
    end else if (acc) begin
      if (acc_ctl.cvalid) begin
        cidx_nxt = cidx_r + lm3d_pkg::CIDX_W'(1);
      end
      pa_nxt = pa_r + lm3d_pkg::PA_W'(1);
      if (x_end) begin
        px_nxt = '0;
        if (y_end) begin
          py_nxt = '0;
          pa_nxt = '0;
          if (z_end) begin
            pz_nxt   = '0;
            cidx_nxt = '0;
          end else begin
            pz_nxt = pz_r + lm3d_pkg::ZW'(1);
          end
        end else begin
          py_nxt = py_r + lm3d_pkg::YW'(1);
        end
      end else begin
        px_nxt = px_r + lm3d_pkg::XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      py_r   <= '0;
      pz_r   <= '0;
      pa_r   <= '0;
      cidx_r <= '0;
    end else begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      pa_r   <= pa_nxt;
      cidx_r <= cidx_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // plane and row memories: read at acceptance, write back from stage 1
  //--------------------------------------------------------------------------
  lm3d_ram #(
    .WIDTH ($bits(lm3d_pkg::ppair_t)),
    .DEPTH (lm3d_pkg::PLANE_DEPTH)
  ) u_plane_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_pa_r),
    .wr_data (plane_wd),
    .rd_en   (acc),
    .rd_addr (pa_r),
    .rd_data (plane_rd)
  );

  lm3d_ram #(
    .WIDTH ($bits(lm3d_pkg::rpair_t)),
    .DEPTH (lm3d_pkg::MAX_X)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data (row_wd),
    .rd_en   (acc),
    .rd_addr (px_r),
    .rd_data (row_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_vox_r <= in_voxel;
      s1_pa_r  <= pa_r;
      s1_x_r   <= px_r;
      s1_ctl_r <= acc_ctl;
    end
  end

  // Same-entry accesses are at least three voxels apart, so the write-back
  // always lands before the next read of that entry.
  always_comb begin
    cur_trip[0] = s1_vox_r;
    cur_trip[1] = plane_rd[1];
    cur_trip[2] = plane_rd[0];
    plane_wd[1] = s1_vox_r;
    plane_wd[0] = plane_rd[1];
    row_wd[0]   = cur_trip;
    row_wd[1]   = row_rd[0];
    for (int zz = 0; zz < 3; zz++) begin
      col[zz][0] = cur_trip[zz];
      col[zz][1] = row_rd[0][zz];
      col[zz][2] = row_rd[1][zz];
    end
  end

  //--------------------------------------------------------------------------
  // stage 2: 3x3x3 window shifted along x, decision
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ctl_r <= s1_ctl_r;
      for (int zz = 0; zz < 3; zz++) begin
        for (int yy = 0; yy < 3; yy++) begin
          win_r[2][zz][yy] <= win_r[1][zz][yy];
          win_r[1][zz][yy] <= win_r[0][zz][yy];
          win_r[0][zz][yy] <= col[zz][yy];
        end
      end
    end
  end

  always_comb begin
    int  k;
    logic gt, lt;
    center = win_r[1][1][1];
    k      = 0;
    nb_ok  = '0;
    for (int xx = 0; xx < 3; xx++) begin
      for (int zz = 0; zz < 3; zz++) begin
        for (int yy = 0; yy < 3; yy++) begin
          if (!(xx == 1 && zz == 1 && yy == 1)) begin
            gt = (center > win_r[xx][zz][yy]);
            lt = (center < win_r[xx][zz][yy]);
            if (fmin_r) begin
              nb_ok[k] = strict_r ? lt : !gt;
            end else begin
              nb_ok[k] = strict_r ? gt : !lt;
            end
            k = k + 1;
          end
        end
      end
    end
    thr_ok = fmin_r ? (center <= cutoff_r) : (center >= cutoff_r);
    s2_ext = s2_ctl_r.inner && thr_ok && (&nb_ok);

    // clear the count at the first voxel of a volume, saturate at the top
    cnt_base = s2_ctl_r.first ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    if (s2_ext && (cnt_base != '1)) begin
      cnt_nxt = cnt_base + lm3d_pkg::CNT_W'(1);
    end
  end

  //--------------------------------------------------------------------------
  // output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (out_take) begin
        out_v_r <= s2_v_r;
      end
      if (s2_adv) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_cv_r  <= s2_ctl_r.cvalid;
      out_idx_r <= s2_ctl_r.cvalid ? s2_ctl_r.cidx : '0;
      out_ext_r <= s2_ext;
    end
  end

  assign out_valid          = out_v_r;
  assign out_center_valid   = out_cv_r;
  assign out_center_index   = out_idx_r;
  assign out_is_extremum    = out_ext_r;
  assign out_extremum_count = cnt_r;

endmodule

>>> hw/rtl/lm3d_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lm3d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/lm3d_checker.sv
// Port-level checker for local_maxima_3d_mask, attached with a bind.
// Depends on lm3d_pkg.
module lm3d_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_center_valid,
  input logic [lm3d_pkg::CIDX_W-1:0]    out_center_index,
  input logic                           out_is_extremum,
  input logic [lm3d_pkg::CNT_W-1:0]     out_extremum_count
);

  // with the result register empty, the pipeline always has room
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_center_valid) &&
      $stable(out_center_index) && $stable(out_is_extremum) &&
      $stable(out_extremum_count))
    else $error("stalled result transaction changed");

  // before the window is full there is no center and no decision
  a_no_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_center_valid |-> (out_center_index == '0) && !out_is_extremum)
    else $error("decision reported without a full window");

  // an extremum is already included in the count it is reported with
  a_count_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_extremum |-> out_extremum_count != '0)
    else $error("extremum reported with zero count");

endmodule

bind local_maxima_3d_mask lm3d_checker u_lm3d_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_center_valid   (out_center_valid),
  .out_center_index   (out_center_index),
  .out_is_extremum    (out_is_extremum),
  .out_extremum_count (out_extremum_count)
);

>>> bench/local_maxima_3d_mask_checker.sv
// Checker for local_maxima_3d_mask: watches the voxel, result and register ports,
// keeps its own copy of the volume state, predicts every decision and compares it.
// Depends on lm3d_pkg for widths, the voxel type and the register indexes.
module local_maxima_3d_mask_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  lm3d_pkg::vox_t                 in_voxel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_center_valid,
  input  logic [lm3d_pkg::CIDX_W-1:0]    out_center_index,
  input  logic                           out_is_extremum,
  input  logic [lm3d_pkg::CNT_W-1:0]     out_extremum_count,
  input  logic                           cfg_we,
  input  logic [lm3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lm3d_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lm3d_pkg::*;

  // two planes, two rows and three voxels of history cover any window
  localparam int unsigned RING_DEPTH = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int          PRINT_CAP  = 40;

  typedef struct packed {
    logic              center_valid;
    logic [CIDX_W-1:0] center_index;
    logic              is_extremum;
    logic [CNT_W-1:0]  extremum_count;
  } decision_t;

  vox_t              voxel_ring [RING_DEPTH];
  int unsigned       ring_wr;
  logic [SIZE_W-1:0] size_x_raw, size_y_raw, size_z_raw;
  vox_t              cutoff_lvl;
  logic              minima_mode, strict_mode;
  int unsigned       pos_x, pos_y, pos_z;
  logic [CNT_W-1:0]  found_count;
  decision_t         pending_decisions [$];
  int                fail_tally = 0;

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] raw,
                                            input int unsigned hi);
    int unsigned w;
    w = raw;
    if (w < 3) begin
      return 3;
    end
    if (w > hi) begin
      return hi;
    end
    return w;
  endfunction

  function automatic vox_t ring_back(input int unsigned back);
    return voxel_ring[(ring_wr + RING_DEPTH - back % RING_DEPTH) % RING_DEPTH];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_tally < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_tally++;
  endtask

  task automatic restart_volume();
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    found_count = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_SIZE_X: begin
        size_x_raw = data[SIZE_W-1:0];
        restart_volume();
      end
      CFG_SIZE_Y: begin
        size_y_raw = data[SIZE_W-1:0];
        restart_volume();
      end
      CFG_SIZE_Z: begin
        size_z_raw = data[SIZE_W-1:0];
        restart_volume();
      end
      CFG_CUTOFF:      cutoff_lvl = data[VOX_W-1:0];
      CFG_FIND_MINIMA: minima_mode = data[0];
      CFG_STRICT:      strict_mode = data[0];
      default: ;  // drop writes to unmapped indexes
    endcase
  endtask

  task automatic predict_center(input vox_t v);
    int unsigned nx, ny, nz, nxy, lag, p, c, cx, cy, cz;
    int          dz, dy, dx, off;
    vox_t        ctr, nb;
    logic        qualifies;
    decision_t   d;
    nx  = clamp_dim(size_x_raw, MAX_X);
    ny  = clamp_dim(size_y_raw, MAX_Y);
    nz  = clamp_dim(size_z_raw, MAX_Z);
    nxy = nx * ny;
    lag = nxy + nx + 1;
    if (pos_x >= nx || pos_y >= ny || pos_z >= nz) begin
      restart_volume();
    end
    if (pos_x == 0 && pos_y == 0 && pos_z == 0) begin
      found_count = '0;
    end
    ring_wr = (ring_wr + 1) % RING_DEPTH;
    voxel_ring[ring_wr] = v;
    p = (pos_z * ny + pos_y) * nx + pos_x;
    d = '0;
    if (p >= lag) begin
      c = p - lag;
      d.center_valid = 1'b1;
      d.center_index = c[CIDX_W-1:0];
      cx = c % nx;
      cy = (c / nx) % ny;
      cz = c / nxy;
      // faces of the volume never qualify
      if (cx >= 1 && cx + 2 <= nx && cy >= 1 && cy + 2 <= ny && cz >= 1 && cz + 2 <= nz) begin
        ctr = ring_back(lag);
        qualifies = minima_mode ? (ctr <= cutoff_lvl) : (ctr >= cutoff_lvl);
        for (dz = -1; dz <= 1; dz++) begin
          for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
              if (dz != 0 || dy != 0 || dx != 0) begin
                off = dz * int'(nxy) + dy * int'(nx) + dx;
                nb  = ring_back(int'(lag) - off);
                if (minima_mode) begin
                  if (strict_mode ? (ctr >= nb) : (ctr > nb)) qualifies = 1'b0;
                end else begin
                  if (strict_mode ? (ctr <= nb) : (ctr < nb)) qualifies = 1'b0;
                end
              end
            end
          end
        end
        d.is_extremum = qualifies;
      end
    end
    if (d.is_extremum && found_count != '1) begin
      found_count = found_count + 1'b1;
    end
    d.extremum_count = found_count;
    pending_decisions.push_back(d);
    pos_x++;
    if (pos_x >= nx) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= ny) begin
        pos_y = 0;
        pos_z++;
        if (pos_z >= nz) pos_z = 0;
      end
    end
  endtask

  always @(posedge clk) begin : watch_ports
    decision_t want;
    if (!rst_n) begin
      size_x_raw  = SIZE_W'(MAX_X);
      size_y_raw  = SIZE_W'(MAX_Y);
      size_z_raw  = SIZE_W'(MAX_Z);
      cutoff_lvl  = '0;
      minima_mode = 1'b0;
      strict_mode = 1'b0;
      ring_wr     = 0;
      restart_volume();
      pending_decisions.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_center(in_voxel);
      if (out_valid && !out_stall) begin
        if (pending_decisions.size() == 0) begin
          report_mismatch("result transaction with no decision pending");
        end else begin
          want = pending_decisions.pop_front();
          if (out_center_valid !== want.center_valid)
            report_mismatch($sformatf("center_valid got %0d, expected %0d",
                                      out_center_valid, want.center_valid));
          if (out_center_index !== want.center_index)
            report_mismatch($sformatf("center_index got %0d, expected %0d",
                                      out_center_index, want.center_index));
          if (out_is_extremum !== want.is_extremum)
            report_mismatch($sformatf("is_extremum got %0d, expected %0d (center %0d)",
                                      out_is_extremum, want.is_extremum, want.center_index));
          if (out_extremum_count !== want.extremum_count)
            report_mismatch($sformatf("extremum_count got %0d, expected %0d",
                                      out_extremum_count, want.extremum_count));
        end
      end
    end
    outstanding <= pending_decisions.size();
    mismatches  <= fail_tally;
  end

endmodule

>>> bench/local_maxima_3d_mask_tb.sv
// Testbench top for local_maxima_3d_mask: drives voxel bursts, register writes and
// result back-pressure; local_maxima_3d_mask_checker predicts and compares.
// Depends on lm3d_pkg, the block and the checker.
module local_maxima_3d_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lm3d_pkg::*;

  // indexes past the register map, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 740;

  typedef enum int {FULL_RANGE, NARROW, RAILS, NEAR_CUTOFF} vox_style_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  vox_t                  in_voxel;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_center_valid;
  logic [CIDX_W-1:0]     out_center_index;
  logic                  out_is_extremum;
  logic [CNT_W-1:0]      out_extremum_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    mismatches;
  int                    outstanding;

  int                    burst_left = 0;
  stall_mode_t           stall_mode = STALL_NONE;
  int                    stall_run = 0;

  local_maxima_3d_mask DUT (.*);

  local_maxima_3d_mask_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result back-pressure: switch between stall patterns after runs of random length
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run  <= $urandom_range(8, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  task automatic send_voxel(input vox_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_voxel <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and let every pending decision come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // value in the low bits, random junk above
  function automatic logic [CFG_W-1:0] noisy(input int unsigned v, input int unsigned w);
    int unsigned mask;
    mask = (32'd1 << w) - 1;
    return CFG_W'(($urandom & ~mask) | (v & mask));
  endfunction

  task automatic set_shape(input int unsigned sx, input int unsigned sy, input int unsigned sz);
    write_reg(CFG_SIZE_X, noisy(sx, SIZE_W));
    write_reg(CFG_SIZE_Y, noisy(sy, SIZE_W));
    write_reg(CFG_SIZE_Z, noisy(sz, SIZE_W));
    close_writes();
  endtask

  task automatic set_mode(input vox_t cut, input logic minima, input logic strict_cmp);
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_FIND_MINIMA, noisy(minima, 1));
    write_reg(CFG_STRICT, noisy(strict_cmp, 1));
    close_writes();
  endtask

  function automatic vox_t pick_voxel(input vox_style_t style, input vox_t cut);
    int r;
    case (style)
      NARROW:      r = int'($urandom_range(0, 6)) - 3;
      RAILS: begin
        case ($urandom_range(0, 3))
          0:       r = -32768;
          1:       r = 32767;
          2:       r = 0;
          default: r = -1;
        endcase
      end
      NEAR_CUTOFF: r = int'(cut) + int'($urandom_range(0, 8)) - 4;
      default:     r = int'($urandom);
    endcase
    return r[VOX_W-1:0];
  endfunction

  function automatic vox_t pick_cutoff();
    int r;
    case ($urandom_range(0, 5))
      0:       r = -32768;
      1:       r = 32767;
      2:       r = 0;
      5:       r = int'($urandom);
      default: r = int'($urandom_range(0, 6)) - 3;
    endcase
    return r[VOX_W-1:0];
  endfunction

  function automatic int unsigned pick_dim();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 2);
    end
    return $urandom_range(3, 6);
  endfunction

  initial begin
    int unsigned sx, sy, sz, vol, n;
    int          random_sent;
    vox_t        cut;
    vox_style_t  style;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_voxel  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape is the largest volume, so the window never fills
    send_voxel(16'h7FFF);
    send_voxel(16'h8000);
    settle();

    // sizes below the minimum count as 3: one inner voxel, a lone peak
    set_shape(0, 1, 2);
    set_mode(16'h8000, 1'b0, 1'b1);
    for (int i = 0; i < 27; i++) begin
      send_voxel((i == 13) ? 16'h7FFF : 16'h8000);
    end
    settle();

    // longest z: many inner decisions in a thin column
    set_shape(3, 3, 300);
    set_mode(16'h0000, 1'b0, 1'b0);
    repeat (120) send_voxel(pick_voxel(NARROW, 16'h0000));
    settle();
    // unmapped writes must leave the volume running
    write_reg(CFG_SPARE_LO, CFG_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_W'($urandom));
    close_writes();
    repeat (20) send_voxel(pick_voxel(NARROW, 16'h0000));
    settle();

    // oversize x clamps to the maximum; window never fills in this stretch
    set_shape(511, 3, 3);
    repeat (40) send_voxel(pick_voxel(FULL_RANGE, 16'h0000));
    settle();

    random_sent = 0;
    sx = 3;
    sy = 3;
    sz = 3;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent == 0 || $urandom_range(0, 4) != 0) begin
        sx = pick_dim();
        sy = pick_dim();
        sz = pick_dim();
        set_shape(sx, sy, sz);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
        close_writes();
      end
      cut = pick_cutoff();
      set_mode(cut, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      style = vox_style_t'($urandom_range(0, 3));
      vol = ((sx < 3) ? 3 : sx) * ((sy < 3) ? 3 : sy) * ((sz < 3) ? 3 : sz);
      n = $urandom_range(vol / 2, 2 * vol);
      // stop at the item budget
      if (int'(n) > RANDOM_ITEMS - random_sent) begin
        n = unsigned'(RANDOM_ITEMS - random_sent);
      end
      repeat (n) begin
        send_voxel(pick_voxel(style, cut));
        random_sent++;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
